// ----- rtl/core/ems_pkg.sv -----
package ems_pkg;

    // Widths fixed by the field list
    localparam int unsigned POS_W    = 17;
    localparam int unsigned STEP_W   = 9;
    localparam int unsigned WIN_W    = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 17;

    // Capture windows around the targets
    localparam logic [POS_W:0] NEAR_SPAN = (POS_W + 1)'(5);
    localparam logic [POS_W:0] TRIG_SPAN = (POS_W + 1)'(4);
    localparam logic [POS_W:0] ALT_LO    = (POS_W + 1)'(730);
    localparam logic [POS_W:0] ALT_HI    = (POS_W + 1)'(1460);

    // Reset values of the registers that do not clear to zero
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(365);
    localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(16);

    // Measurement phases
    typedef enum logic [2:0] {
        PH_APPROACH = 3'd0,
        PH_START    = 3'd1,
        PH_MEASURE  = 3'd2,
        PH_WAIT     = 3'd3,
        PH_IDLE     = 3'd4
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_APPROACH  = 3'd0,
        REG_START     = 3'd1,
        REG_END_INIT  = 3'd2,
        REG_END_ALT   = 3'd3,
        REG_FIRST_TRG = 3'd4,
        REG_STEP      = 3'd5,
        REG_END_WIN   = 3'd6,
        REG_FULL_TURN = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0]  approach_target;
        logic [POS_W-1:0]  start_target;
        logic [POS_W-1:0]  end_target_init;
        logic [POS_W-1:0]  end_alternate;
        logic [POS_W-1:0]  first_trigger;
        logic [STEP_W-1:0] step_counts;
        logic [WIN_W-1:0]  end_window;
        logic              full_turn;
    } cfg_t;

    // One input item, first field in the highest bits
    typedef struct packed {
        logic             cmd;
        logic             has_samples;
        logic             data_pending;
        logic             adc_busy;
        logic [POS_W-1:0] position;
    } item_t;

    // One result item, first field in the highest bits
    typedef struct packed {
        logic       approaching;
        logic       publish_data;
        logic       finish_event;
        logic [1:0] pulse_count;
        logic       reverse_event;
        logic [2:0] phase_now;
    } result_t;

    localparam int unsigned RES_W   = $bits(result_t);
    localparam int unsigned OUT_W   = ((RES_W + 7) / 8) * 8;
    localparam int unsigned IN_DW   = POS_W + 3;
    localparam int unsigned IN_W    = ((IN_DW + 7) / 8) * 8;

endpackage

// ----- rtl/core/ems_cfg.sv -----
module ems_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [2:0]           wr_index,
    input  logic [16:0]          wr_data,
    output ems_pkg::cfg_t        cfg
);
    import ems_pkg::*;

    cfg_t cfg_reg;

    // Decode the register index and load the addressed field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.approach_target <= '0;
            cfg_reg.start_target    <= '0;
            cfg_reg.end_target_init <= '0;
            cfg_reg.end_alternate   <= '0;
            cfg_reg.first_trigger   <= '0;
            cfg_reg.step_counts     <= STEP_RESET;
            cfg_reg.end_window      <= WIN_RESET;
            cfg_reg.full_turn       <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_APPROACH:  cfg_reg.approach_target <= wr_data[POS_W-1:0];
                REG_START:     cfg_reg.start_target    <= wr_data[POS_W-1:0];
                REG_END_INIT:  cfg_reg.end_target_init <= wr_data[POS_W-1:0];
                REG_END_ALT:   cfg_reg.end_alternate   <= wr_data[POS_W-1:0];
                REG_FIRST_TRG: cfg_reg.first_trigger   <= wr_data[POS_W-1:0];
                REG_STEP:      cfg_reg.step_counts     <= wr_data[STEP_W-1:0];
                REG_END_WIN:   cfg_reg.end_window      <= wr_data[WIN_W-1:0];
                REG_FULL_TURN: cfg_reg.full_turn       <= wr_data[0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/ems_core.sv -----
module ems_core #(
    parameter int unsigned ENC_COUNTS = 131072
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  ems_pkg::item_t   item,
    input  ems_pkg::cfg_t    cfg,
    output ems_pkg::result_t res
);
    import ems_pkg::*;

    // Trigger point must hold both a 17-bit start value and one revolution
    localparam int unsigned TRIG_W = (ENC_COUNTS > (1 << POS_W)) ?
                                     $clog2(ENC_COUNTS) : POS_W;
    localparam logic [TRIG_W:0] REV_COUNTS = (TRIG_W + 1)'(ENC_COUNTS);

    phase_t            phase_reg, phase_next;
    logic [TRIG_W-1:0] trig_reg, trig_next;
    logic [POS_W-1:0]  goal_reg, goal_next;

    logic [POS_W:0]    pos_x;
    logic [TRIG_W:0]   pos_t;
    logic [TRIG_W:0]   trig_x;
    logic [TRIG_W:0]   trig_sum;
    logic [TRIG_W:0]   trig_wrap;
    logic              hit_app;
    logic              hit_start;
    logic              hit_end;
    logic              hit_trig;
    logic              hit_alt;

    // Window compares, all linear with one bit of headroom
    always_comb
    begin
        pos_x   = {1'b0, item.position};
        pos_t   = (TRIG_W + 1)'(item.position);
        trig_x  = {1'b0, trig_reg};
        hit_app = (pos_x + NEAR_SPAN >= {1'b0, cfg.approach_target}) &&
                  (pos_x <= {1'b0, cfg.approach_target} + NEAR_SPAN);
        hit_start = (pos_x + NEAR_SPAN >= {1'b0, cfg.start_target}) &&
                    (pos_x <= {1'b0, cfg.start_target} + NEAR_SPAN);
        hit_end = (pos_x >= {1'b0, goal_reg}) &&
                  (pos_x <= {1'b0, goal_reg} + (POS_W + 1)'(cfg.end_window));
        hit_alt = (pos_x >= {1'b0, cfg.end_alternate} + ALT_LO) &&
                  (pos_x <= {1'b0, cfg.end_alternate} + ALT_HI);
        hit_trig = (pos_t + (TRIG_W + 1)'(TRIG_SPAN) >= trig_x) &&
                   (pos_t <= trig_x + (TRIG_W + 1)'(TRIG_SPAN));
        // Advance the trigger point and wrap once at one revolution
        trig_sum  = trig_x + (TRIG_W + 1)'(cfg.step_counts);
        trig_wrap = (trig_sum >= REV_COUNTS) ? (trig_sum - REV_COUNTS) : trig_sum;
    end

    // Phase cascade for one item
    always_comb
    begin
        phase_t ph;
        ph         = phase_reg;
        trig_next  = trig_reg;
        goal_next  = goal_reg;
        res        = '0;
        if (item.cmd)
        begin
            ph        = PH_APPROACH;
            trig_next = TRIG_W'(cfg.first_trigger);
            goal_next = cfg.end_target_init;
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (ph == PH_APPROACH && hit_app)
            begin
                res.reverse_event = 1'b1;
                ph                = PH_START;
            end
            if (ph == PH_START && hit_start)
            begin
                res.pulse_count = res.pulse_count + 2'd1;
                ph              = PH_MEASURE;
            end
            if (ph == PH_MEASURE)
            begin
                if (hit_end)
                begin
                    res.pulse_count = res.pulse_count + 2'd1;
                    ph              = PH_WAIT;
                end
                else
                begin
                    if (hit_trig)
                    begin
                        trig_next       = trig_wrap[TRIG_W-1:0];
                        res.pulse_count = res.pulse_count + 2'd1;
                    end
                    if (cfg.full_turn && hit_alt)
                    begin
                        goal_next = cfg.end_alternate;
                    end
                end
            end
            else if (ph == PH_WAIT && !item.adc_busy && !item.data_pending)
            begin
                res.finish_event = 1'b1;
                res.publish_data = item.has_samples;
                ph               = PH_IDLE;
            end
        end
        phase_next      = ph;
        res.phase_now   = phase_next;
        res.approaching = (phase_next == PH_APPROACH);
    end

    // Hold the sequencer state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            trig_reg  <= '0;
            goal_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            trig_reg  <= trig_next;
            goal_reg  <= goal_next;
        end
    end

    // Finish always leaves the block idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.finish_event) |=> (phase_reg == PH_IDLE))
        else $error("finish did not leave the block idle");

    // Published data only comes with a finish
    a_publish_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (res.publish_data) |-> (res.finish_event))
        else $error("publish without finish");

    // An arm always restarts at approach with the first trigger loaded
    a_arm_load: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item.cmd) |=>
        (phase_reg == PH_APPROACH) && (trig_reg == TRIG_W'($past(cfg.first_trigger))))
        else $error("arm did not load the sequencer");

endmodule

// ----- rtl/core/encoder_measurement_sequencer.sv -----
// Encoder measurement sequencer.
// Configuration: write beats on cfg_valid/cfg_ready carry a register index
// (cfg_index) and data (cfg_data); cfg_ready is always high. Write only while
// the block is idle (no item in flight).
// Input stream: s_axis_tuser is the command (0 position sample, 1 arm),
// s_axis_tdata carries the position and the converter/buffer flags.
// Output stream: one result beat per input beat, in order, on m_axis_*.
// Each beat passes an input register, one step of compare/add logic that
// also updates the phase, trigger point and end goal, and a result register.
// A beat accepted into the input register moves into the result register when the
// output is free, and is presented on m_axis from there. Throughput: one beat
// per cycle while the receiver does not stall, set by the state update loop,
// which closes through the core's state registers alone.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, then s_axis_tready drops until the result moves.
// Reset: phase idle, trigger point and end goal zero, step 365, end window
// 16, all other registers zero; both pipeline registers empty.
module encoder_measurement_sequencer #(
    parameter int unsigned ENC_COUNTS = 131072
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: position[16:0], adc_busy[17], data_pending[18], has_samples[19]
    input  logic [23:0] s_axis_tdata,
    // tuser: cmd[0]
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: phase_now[2:0], reverse_event[3], pulse_count[5:4],
    //        finish_event[6], publish_data[7], approaching[8]
    output logic [15:0] m_axis_tdata
);
    import ems_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    ems_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the held beat forward whenever the result register can take it
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg <= {s_axis_tuser, s_axis_tdata[IN_DW-1:0]};
        end
    end

    ems_core #(
        .ENC_COUNTS (ENC_COUNTS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - RES_W)'(0), res_reg};

    // Input only stalls behind a full, blocked result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tready) |-> (in_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // Every advanced beat is presented on the next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced beat not presented");

    // A new result appears only after a beat advanced
    a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(advance))
        else $error("result appeared without an item");

endmodule

// ----- tb/encoder_measurement_sequencer_tb.sv -----
module encoder_measurement_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ems_pkg::*;

    localparam int unsigned REV_COUNTS = 131072;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 s_tuser;
    logic                 m_axis_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_axis_tdata;

    // Shadow of the sequencer: registers and measurement state
    cfg_t        shadow;
    phase_t      st_phase;
    logic [16:0] trig_point;
    logic [16:0] end_goal;

    // Predicted status beats, oldest first
    result_t status_queue[$];

    int src_idle_pct;
    int sink_stall_pct;
    int errors;
    int n_items;
    int n_results;
    int n_finish;
    int n_pulses;
    int n_cfg_writes;
    int cfg_round;

    encoder_measurement_sequencer #(
        .ENC_COUNTS(REV_COUNTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Linear window compare, no wrap at the revolution
    function automatic bit in_window(input logic [16:0] pos, input logic [16:0] ctr,
                                     input int lo, input int hi);
        int p;
        int c;
        p = int'(pos);
        c = int'(ctr);
        return (p >= c + lo) && (p <= c + hi);
    endfunction

    // Advance the measurement by one beat and return the status it produces
    function automatic result_t predict_step(input item_t it);
        result_t     r;
        logic [17:0] adv;
        r = '0;
        if (it.cmd)
        begin
            st_phase   = PH_APPROACH;
            trig_point = shadow.first_trigger;
            end_goal   = shadow.end_target_init;
        end
        else if (st_phase <= PH_WAIT)
        begin
            if (st_phase == PH_APPROACH &&
                in_window(it.position, shadow.approach_target, -5, 5))
            begin
                r.reverse_event = 1'b1;
                st_phase = PH_START;
            end
            if (st_phase == PH_START && in_window(it.position, shadow.start_target, -5, 5))
            begin
                r.pulse_count += 2'd1;
                st_phase = PH_MEASURE;
            end
            if (st_phase == PH_MEASURE)
            begin
                if (in_window(it.position, end_goal, 0, int'(shadow.end_window)))
                begin
                    r.pulse_count += 2'd1;
                    st_phase = PH_WAIT;
                end
                else
                begin
                    if (in_window(it.position, trig_point, -4, 4))
                    begin
                        adv = {1'b0, trig_point} + {9'd0, shadow.step_counts};
                        if (adv >= REV_COUNTS)
                            adv = adv - 18'(REV_COUNTS);
                        trig_point = adv[16:0];
                        r.pulse_count += 2'd1;
                    end
                    if (shadow.full_turn &&
                        in_window(it.position, shadow.end_alternate, 730, 1460))
                        end_goal = shadow.end_alternate;
                end
            end
            else if (st_phase == PH_WAIT && !it.adc_busy && !it.data_pending)
            begin
                r.finish_event = 1'b1;
                r.publish_data = it.has_samples;
                st_phase = PH_IDLE;
            end
        end
        r.phase_now   = st_phase;
        r.approaching = (st_phase == PH_APPROACH);
        return r;
    endfunction

    function automatic item_t mk_item(input logic cmd, input int pos, input logic busy,
                                      input logic pend, input logic have);
        item_t it;
        it.cmd          = cmd;
        it.position     = 17'(pos);
        it.adc_busy     = busy;
        it.data_pending = pend;
        it.has_samples  = have;
        return it;
    endfunction

    function automatic logic [16:0] offset_pos(input logic [16:0] base, input int off);
        return 17'(int'(base) + off);
    endfunction

    // Steer the next beat toward the window the measurement is looking for
    function automatic item_t make_item();
        item_t it;
        int    r;
        it.cmd          = 1'b0;
        it.position     = 17'($urandom);
        it.adc_busy     = 1'($urandom_range(1));
        it.data_pending = 1'($urandom_range(1));
        it.has_samples  = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (r < 8)
        begin
            it.cmd = 1'($urandom_range(1));
            return it;
        end
        case (st_phase)
            PH_IDLE:
                it.cmd = ($urandom_range(99) < 85);
            PH_APPROACH:
                it.position = offset_pos(shadow.approach_target, $urandom_range(14) - 7);
            PH_START:
                it.position = offset_pos(shadow.start_target, $urandom_range(14) - 7);
            PH_MEASURE:
            begin
                r = $urandom_range(99);
                if (r < 50)
                    it.position = offset_pos(trig_point, $urandom_range(12) - 6);
                else if (r < 65)
                    it.position = offset_pos(end_goal,
                                             $urandom_range(int'(shadow.end_window) + 6) - 3);
                else if (r < 80)
                    it.position = offset_pos(shadow.end_alternate, $urandom_range(720, 1470));
            end
            default:
                ;
        endcase
        // Abort now and then with a fresh arm
        if (st_phase != PH_IDLE && $urandom_range(99) < 2)
            it.cmd = 1'b1;
        return it;
    endfunction

    // Drive one beat at the falling edge, record the prediction on acceptance
    task automatic send_item(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_W'({it.has_samples, it.data_pending, it.adc_busy, it.position});
        s_tuser  = it.cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        status_queue.push_back(predict_step(it));
        n_items++;
    endtask

    // Hold the input and wait until every predicted status has come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [16:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_APPROACH:  shadow.approach_target = val;
            REG_START:     shadow.start_target    = val;
            REG_END_INIT:  shadow.end_target_init = val;
            REG_END_ALT:   shadow.end_alternate   = val;
            REG_FIRST_TRG: shadow.first_trigger   = val;
            REG_STEP:      shadow.step_counts     = val[STEP_W-1:0];
            REG_END_WIN:   shadow.end_window      = val[WIN_W-1:0];
            REG_FULL_TURN: shadow.full_turn       = val[0];
            default:       ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Rotate through all-low, mostly high and random register settings
    task automatic load_settings(input int mode);
        logic [16:0] step;
        logic [16:0] win;
        case (mode)
            0:
            begin
                write_reg(REG_APPROACH, 17'd0);
                write_reg(REG_START, 17'd0);
                write_reg(REG_END_INIT, 17'd0);
                write_reg(REG_END_ALT, 17'd0);
                write_reg(REG_FIRST_TRG, 17'd0);
                write_reg(REG_STEP, 17'd0);
                write_reg(REG_END_WIN, 17'd0);
                write_reg(REG_FULL_TURN, 17'd0);
            end
            1:
            begin
                write_reg(REG_APPROACH, 17'h1FFFF);
                write_reg(REG_START, 17'h1FFFF);
                write_reg(REG_END_INIT, 17'h1FFFF);
                write_reg(REG_END_ALT, 17'h1FFFF);
                write_reg(REG_FIRST_TRG, 17'h1FFFF);
                write_reg(REG_STEP, 17'd365);
                write_reg(REG_END_WIN, 17'd4095);
                write_reg(REG_FULL_TURN, 17'd1);
            end
            default:
            begin
                step = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 17'd511 : 17'd0)
                                                : 17'($urandom_range(1, 365));
                win  = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 17'd4095 : 17'd0)
                                                : 17'($urandom_range(4095));
                write_reg(REG_APPROACH, 17'($urandom));
                write_reg(REG_START, 17'($urandom));
                write_reg(REG_END_INIT, 17'($urandom));
                write_reg(REG_END_ALT, 17'($urandom));
                // Often place the first trigger just below the wrap point
                write_reg(REG_FIRST_TRG, ($urandom_range(2) == 0) ?
                                         17'(131071 - $urandom_range(600)) : 17'($urandom));
                write_reg(REG_STEP, step);
                write_reg(REG_END_WIN, win);
                write_reg(REG_FULL_TURN, 17'($urandom_range(1)));
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each status beat against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            got = result_t'(m_axis_tdata[RES_W-1:0]);
            if (status_queue.size() == 0)
            begin
                $display("%0t: unexpected status beat, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = status_queue.pop_front();
                check_field("phase_now", want.phase_now, got.phase_now);
                check_field("reverse_event", want.reverse_event, got.reverse_event);
                check_field("pulse_count", want.pulse_count, got.pulse_count);
                check_field("finish_event", want.finish_event, got.finish_event);
                check_field("publish_data", want.publish_data, got.publish_data);
                check_field("approaching", want.approaching, got.approaching);
                n_results++;
                n_finish += want.finish_event;
                n_pulses += want.pulse_count;
            end
        end
    end

    // Randomize the ready line at every falling edge
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_stall_pct);

    // Samples with the block idle and default registers
    task automatic test_idle_after_reset();
        send_item(mk_item(1'b0, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 131071, 1'b1, 1'b1, 1'b1));
        wait_drained();
    endtask

    // Full walk: two-trigger start beat, zero step, alternate swap, end, finish
    task automatic test_full_turn_walk();
        write_reg(REG_APPROACH, 17'd1000);
        write_reg(REG_START, 17'd900);
        write_reg(REG_END_INIT, 17'd5000);
        write_reg(REG_END_ALT, 17'd2000);
        write_reg(REG_FIRST_TRG, 17'd908);
        write_reg(REG_STEP, 17'd0);
        write_reg(REG_END_WIN, 17'd16);
        write_reg(REG_FULL_TURN, 17'd1);
        send_item(mk_item(1'b1, 131071, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(1'b0, 994, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 995, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 906, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 905, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 912, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 913, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 2729, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 2730, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 2017, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 2016, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 0, 1'b1, 1'b0, 1'b1));
        send_item(mk_item(1'b0, 0, 1'b0, 1'b1, 1'b1));
        send_item(mk_item(1'b0, 0, 1'b0, 1'b0, 1'b1));
        send_item(mk_item(1'b0, 2016, 1'b0, 1'b0, 1'b1));
        wait_drained();
    endtask

    // Edge targets, trigger wrap, no swap with full turn off, finish without data
    task automatic test_wrap_and_edges();
        write_reg(REG_APPROACH, 17'd0);
        write_reg(REG_START, 17'h1FFFF);
        write_reg(REG_END_INIT, 17'h1FFFF);
        write_reg(REG_END_ALT, 17'd0);
        write_reg(REG_FIRST_TRG, 17'd131070);
        write_reg(REG_STEP, 17'd365);
        write_reg(REG_END_WIN, 17'd0);
        write_reg(REG_FULL_TURN, 17'd0);
        send_item(mk_item(1'b1, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 131066, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 363, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 730, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 131071, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(1'b0, 65536, 1'b0, 1'b0, 1'b0));
        wait_drained();
    endtask

    // Steered random traffic, re-programmed every hundred live beats
    task automatic test_random_traffic(input int n, input int src_pct, input int sink_pct);
        item_t it;
        int    live;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        live = 0;
        while (live < n)
        begin
            if (live % 100 == 0)
            begin
                wait_drained();
                load_settings(cfg_round % 6);
                cfg_round++;
            end
            it = make_item();
            // Samples taken while idle do not move the block
            if (it.cmd || st_phase != PH_IDLE)
                live++;
            send_item(it);
        end
        wait_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_APPROACH;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        errors         = 0;
        n_items        = 0;
        n_results      = 0;
        n_finish       = 0;
        n_pulses       = 0;
        n_cfg_writes   = 0;
        cfg_round      = 0;
        shadow         = '0;
        shadow.step_counts = STEP_RESET;
        shadow.end_window  = WIN_RESET;
        st_phase       = PH_IDLE;
        trig_point     = '0;
        end_goal       = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_idle_after_reset();
        test_full_turn_walk();
        test_wrap_and_edges();
        test_random_traffic(400, 0, 0);
        test_random_traffic(300, 80, 0);
        test_random_traffic(300, 0, 80);
        test_random_traffic(400, 38, 38);
        test_random_traffic(300, 0, 0);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d beats and %0d status beats over %0d register writes,",
                 n_items, n_results, n_cfg_writes);
        $display("with %0d finished measurements and %0d detector triggers.",
                 n_finish, n_pulses);
        if (errors == 0 && status_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d status beats outstanding", status_queue.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
